/* hdl/three_channel_echo_ranging_alert_defines.svh */
// Assertion macros used by the echo ranging alert controller.
`ifndef THREE_CHANNEL_ECHO_RANGING_ALERT_DEFINES_SVH
`define THREE_CHANNEL_ECHO_RANGING_ALERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCERA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcera: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCERA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcera: next-cycle check failed");

`endif

/* hdl/tcera_pkg.sv */
// Package: widths, register indexes, op codes and control structs.
`timescale 1ns / 1ps

package tcera_pkg;

    localparam int TIMER_BITS = 16;
    localparam int SUM_BITS   = 24;

    localparam int BOUND_W = 10;
    localparam int TICKS_W = 16;
    localparam int SAMP_W  = 8;
    localparam int LIM_W   = BOUND_W + SAMP_W;
    localparam int CH_W    = 2;
    localparam int NUM_CH  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_CNT_W = $clog2(TIMER_BITS);

    localparam int S_TDATA_W = ((TIMER_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = CH_W + 1;
    localparam int M_TDATA_W = ((3 + CH_W + SUM_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 1 + CH_W;

    localparam logic [BOUND_W-1:0] BOUND_RST = BOUND_W'(70);
    localparam logic [TICKS_W-1:0] TICKS_RST = TICKS_W'(377);
    localparam logic [SAMP_W-1:0]  SAMP_RST  = SAMP_W'(50);

    localparam logic [CFG_IDX_W-1:0] REG_BOUND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd2;

    localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
    localparam logic [CH_W-1:0] CH_MIDDLE = 2'd1;
    localparam logic [CH_W-1:0] CH_RIGHT  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RISE,
        OP_ROUND,
        OP_ADD
    } op_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic rising;
        logic round_end;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* hdl/tcera_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tcera_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [tcera_pkg::TIMER_BITS-1:0] dividend,
    input  logic [tcera_pkg::TIMER_BITS-1:0] divisor,
    output logic                             done,
    output logic [tcera_pkg::TIMER_BITS-1:0] quotient
);
    import tcera_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIMER_BITS-1:0] rem_reg, rem_next;
    logic [TIMER_BITS-1:0] quo_reg, quo_next;
    logic [TIMER_BITS-1:0] dvs_reg, dvs_next;
    logic [TIMER_BITS:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[TIMER_BITS-1]} - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[TIMER_BITS]) begin
                rem_next = trial[TIMER_BITS-1:0];
                quo_next = {quo_reg[TIMER_BITS-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[TIMER_BITS-2:0], quo_reg[TIMER_BITS-1]};
                quo_next = {quo_reg[TIMER_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(TIMER_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/tcera_dp.sv */
// Datapath: settings, per-sensor state, divider, flag limit, output register.
`timescale 1ns / 1ps

module tcera_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [tcera_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcera_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tcera_pkg::CH_W-1:0]       in_ch,
    input  logic                             in_rise,
    input  logic [tcera_pkg::TIMER_BITS-1:0] in_time,
    input  tcera_pkg::cmd_t                  cmd,
    output tcera_pkg::sts_t                  sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcera_pkg::M_TDATA_W-1:0]  out_tdata,
    output logic [tcera_pkg::M_TUSER_W-1:0]  out_tuser
);
    import tcera_pkg::*;

    logic [BOUND_W-1:0] bound_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [SAMP_W-1:0]  samples_reg;
    logic [LIM_W-1:0]   lim_reg;

    logic [CH_W-1:0]       item_ch_reg;
    logic                  item_rise_reg;
    logic [TIMER_BITS-1:0] item_time_reg;

    logic [CH_W-1:0]       active_reg, active_next;
    logic                  back_reg, back_next;
    logic [TIMER_BITS-1:0] rise_reg  [NUM_CH], rise_next  [NUM_CH];
    logic [SAMP_W-1:0]     tally_reg [NUM_CH], tally_next [NUM_CH];
    logic [SUM_BITS-1:0]   run_reg   [NUM_CH], run_next   [NUM_CH];
    logic [SUM_BITS-1:0]   fin_reg   [NUM_CH], fin_next   [NUM_CH];

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_tdata_reg, out_tdata_next;
    logic [M_TUSER_W-1:0]  out_tuser_reg, out_tuser_next;

    logic [TIMER_BITS-1:0] width;
    logic [TIMER_BITS-1:0] divisor;
    logic [TIMER_BITS-1:0] quotient;
    logic                  div_done;
    logic [SUM_BITS:0]     sum_wide;
    logic [SUM_BITS-1:0]   sum_sat;
    logic [NUM_CH-1:0]     near;

    assign width   = item_time_reg - rise_reg[active_reg];
    assign divisor = (ticks_reg == '0) ? TIMER_BITS'(1) : TIMER_BITS'(ticks_reg);

    tcera_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (width),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sum_wide = {1'b0, run_reg[active_reg]} + (SUM_BITS + 1)'(quotient);
    assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    assign sts.hit       = (item_ch_reg == active_reg);
    assign sts.rising    = item_rise_reg;
    assign sts.round_end = (tally_reg[active_reg] == samples_reg);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb begin
        active_next = active_reg;
        back_next   = back_reg;
        rise_next   = rise_reg;
        tally_next  = tally_reg;
        run_next    = run_reg;
        fin_next    = fin_reg;
        case (cmd.op)
            OP_RISE: begin
                rise_next[active_reg] = item_time_reg;
            end
            OP_ROUND: begin
                fin_next[active_reg]   = run_reg[active_reg];
                run_next[active_reg]   = '0;
                tally_next[active_reg] = '0;
                case (active_reg)
                    CH_LEFT: begin
                        active_next = CH_MIDDLE;
                        back_next   = 1'b0;
                    end
                    CH_MIDDLE: begin
                        active_next = back_reg ? CH_LEFT : CH_RIGHT;
                    end
                    default: begin
                        active_next = CH_MIDDLE;
                        back_next   = 1'b1;
                    end
                endcase
            end
            OP_ADD: begin
                run_next[active_reg]   = sum_sat;
                tally_next[active_reg] = tally_reg[active_reg] + 1'b1;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < NUM_CH; i++) begin
            near[i] = (fin_next[i] != '0) &&
                      ((SUM_BITS + LIM_W)'(fin_next[i]) <= (SUM_BITS + LIM_W)'(lim_reg));
        end
        // tdata: near_left, near_middle, near_right, serving_channel, done_sum
        out_tdata_next = M_TDATA_W'({(cmd.op == OP_ROUND) ? run_reg[active_reg]
                                                           : {SUM_BITS{1'b0}},
                                     active_next, near[2], near[1], near[0]});
        // tuser: average_done, done_channel
        out_tuser_next = (cmd.op == OP_ROUND) ? {active_reg, 1'b1} : {CH_W'(0), 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg     <= BOUND_RST;
            ticks_reg     <= TICKS_RST;
            samples_reg   <= SAMP_RST;
            active_reg    <= CH_LEFT;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                rise_reg[i]  <= '0;
                tally_reg[i] <= '0;
                run_reg[i]   <= '0;
                fin_reg[i]   <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_BOUND:   bound_reg   <= cfg_data[BOUND_W-1:0];
                    REG_TICKS:   ticks_reg   <= cfg_data[TICKS_W-1:0];
                    REG_SAMPLES: samples_reg <= cfg_data[SAMP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.commit) begin
                active_reg    <= active_next;
                back_reg      <= back_next;
                rise_reg      <= rise_next;
                tally_reg     <= tally_next;
                run_reg       <= run_next;
                fin_reg       <= fin_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        lim_reg <= LIM_W'(bound_reg) * LIM_W'(samples_reg);
        if (cmd.load) begin
            item_ch_reg   <= in_ch;
            item_rise_reg <= in_rise;
            item_time_reg <= in_time;
        end
        if (cmd.commit) begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= out_tuser_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = out_tdata_reg;
    assign out_tuser = out_tuser_reg;

endmodule

/* hdl/tcera_ctrl.sv */
// Controller: sequences accept, decode, divide and commit for one beat.
`timescale 1ns / 1ps

`include "three_channel_echo_ranging_alert_defines.svh"

module tcera_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  tcera_pkg::sts_t sts,
    output tcera_pkg::cmd_t cmd
);
    import tcera_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        cmd.op        = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.hit) begin
                    op_next = OP_NONE;
                end else if (sts.rising) begin
                    op_next = OP_RISE;
                end else if (sts.round_end) begin
                    op_next = OP_ROUND;
                end else begin
                    op_next = OP_ADD;
                end
                if (sts.hit && !sts.rising && !sts.round_end) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.op = op_reg;
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    `TCERA_ASSERT_NXT(a_take_decodes, aclk, aresetn, take, state_reg == ST_DECODE)
    `TCERA_ASSERT_IMP(a_commit_free, aclk, aresetn, cmd.commit, sts.out_free)
    `TCERA_ASSERT_NXT(a_div_to_commit, aclk, aresetn, (state_reg == ST_DIV) && sts.div_done,
                      state_reg == ST_COMMIT)
    `TCERA_ASSERT_IMP(a_div_only_add, aclk, aresetn, cmd.div_start,
                      sts.hit && !sts.rising && !sts.round_end)

endmodule

/* hdl/three_channel_echo_ranging_alert.sv */
// Top level: three-sensor ultrasonic echo ranging with proximity alerts.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------------
//  s_       in   s_tvalid/s_tready  tdata capture_time; tuser channel, edge_rising
//  m_       out  m_tvalid/m_tready  tdata flags, serving ch, sum; tuser done info
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data (bound, ticks, samples)
//
// Rising edges, edges on an idle sensor and round-ending falling edges go
// from decode straight to the commit step; a summing falling edge first
// waits in the divide step for the 16-step shared restoring divider (one
// quotient bit per cycle). The input is freed once the result is committed.
// One beat is in flight at a time; a new beat is taken while the last result
// waits in the output register. A held m_tready stalls only the commit step.
// aresetn is synchronous, active low, and restores all settings, per-sensor and control state.
`timescale 1ns / 1ps

module three_channel_echo_ranging_alert (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcera_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] capture_time
    input  logic [tcera_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] channel, [2] edge_rising
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] near_left, [1] near_middle, [2] near_right, [4:3] serving_channel,
    // [28:5] done_sum, upper bits zero
    output logic [tcera_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [tcera_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] average_done, [2:1] done_channel
    // settings writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcera_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcera_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcera_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // settings always taken; sender must write them only while no beat is in flight; unchecked
    assign cfg_ready = 1'b1;

    tcera_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcera_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (s_tuser[CH_W-1:0]),
        .in_rise   (s_tuser[CH_W]),
        .in_time   (s_tdata[TIMER_BITS-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

endmodule

/* tb/echo_range_checker.sv */
// Checker: predicts each result beat of the echo ranging block and compares it.
`timescale 1ns / 1ps

module echo_range_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [tcera_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] capture_time
    input  logic [tcera_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] channel, [2] edge_rising
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] near_left, [1] near_middle, [2] near_right, [4:3] serving_channel, [28:5] done_sum
    input  logic [tcera_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [tcera_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] average_done, [2:1] done_channel
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tcera_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcera_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               errors,
    output int                               pending,
    output logic [tcera_pkg::CH_W-1:0]       serving
);
    import tcera_pkg::*;

    typedef struct packed {
        logic                near_left;
        logic                near_middle;
        logic                near_right;
        logic [CH_W-1:0]     serving;
        logic                avg_done;
        logic [CH_W-1:0]     done_ch;
        logic [SUM_BITS-1:0] done_sum;
    } echo_result_t;

    logic [BOUND_W-1:0]    bound_cm;
    logic [TICKS_W-1:0]    ticks_per_cm;
    logic [SAMP_W-1:0]     samples_per_avg;
    logic [CH_W-1:0]       active_sensor;
    logic                  heading_back;
    logic [TIMER_BITS-1:0] rise_stamp [NUM_CH];
    logic [SAMP_W-1:0]     sample_tally [NUM_CH];
    logic [SUM_BITS-1:0]   running_total [NUM_CH];
    logic [SUM_BITS-1:0]   finished_total [NUM_CH];
    echo_result_t          want_results [$];
    int                    beat_no;

    // average within bound, done as a nonzero sum <= bound * samples
    function automatic logic near_flag(logic [CH_W-1:0] ch);
        logic [LIM_W-1:0] lim;
        lim = bound_cm * samples_per_avg;
        return (finished_total[ch] != '0) && (finished_total[ch] <= lim);
    endfunction

    function automatic echo_result_t range_step(logic [CH_W-1:0] ch, logic rising,
                                                logic [TIMER_BITS-1:0] t);
        echo_result_t          r;
        logic [TIMER_BITS-1:0] width;
        logic [TICKS_W-1:0]    divisor;
        logic [SUM_BITS:0]     sum;
        r = '0;
        // active_sensor is never 3, so the unused code falls through as idle
        if (ch == active_sensor) begin
            if (rising) begin
                rise_stamp[ch] = t;
            end else if (sample_tally[ch] == samples_per_avg) begin
                finished_total[ch] = running_total[ch];
                running_total[ch]  = '0;
                sample_tally[ch]   = '0;
                r.avg_done = 1'b1;
                r.done_ch  = ch;
                r.done_sum = finished_total[ch];
                case (active_sensor)
                    CH_LEFT: begin
                        active_sensor = CH_MIDDLE;
                        heading_back  = 1'b0;
                    end
                    CH_MIDDLE: begin
                        active_sensor = heading_back ? CH_LEFT : CH_RIGHT;
                    end
                    default: begin
                        active_sensor = CH_MIDDLE;
                        heading_back  = 1'b1;
                    end
                endcase
            end else begin
                width   = t - rise_stamp[ch];
                divisor = (ticks_per_cm == '0) ? TICKS_W'(1) : ticks_per_cm;
                sum     = {1'b0, running_total[ch]} + (SUM_BITS + 1)'(width / divisor);
                running_total[ch] = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
                sample_tally[ch]  = sample_tally[ch] + 1'b1;
            end
        end
        r.near_left   = near_flag(CH_LEFT);
        r.near_middle = near_flag(CH_MIDDLE);
        r.near_right  = near_flag(CH_RIGHT);
        r.serving     = active_sensor;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR result %0d: %s", beat_no, msg);
        errors++;
    endtask

    task automatic check_field(string field, longint got, longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    always @(posedge aclk) begin
        echo_result_t got;
        echo_result_t want;
        if (!aresetn) begin
            bound_cm        = BOUND_RST;
            ticks_per_cm    = TICKS_RST;
            samples_per_avg = SAMP_RST;
            active_sensor   = CH_LEFT;
            heading_back    = 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                rise_stamp[i]     = '0;
                sample_tally[i]   = '0;
                running_total[i]  = '0;
                finished_total[i] = '0;
            end
            want_results.delete();
            beat_no = 0;
            errors  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BOUND:   bound_cm        = cfg_data[BOUND_W-1:0];
                    REG_TICKS:   ticks_per_cm    = cfg_data[TICKS_W-1:0];
                    REG_SAMPLES: samples_per_avg = cfg_data[SAMP_W-1:0];
                    default: ;
                endcase
            end
            // older results leave before the beat taken at this edge is predicted
            if (m_tvalid && m_tready) begin
                got.near_left   = m_tdata[0];
                got.near_middle = m_tdata[1];
                got.near_right  = m_tdata[2];
                got.serving     = m_tdata[3 +: CH_W];
                got.done_sum    = m_tdata[5 +: SUM_BITS];
                got.avg_done    = m_tuser[0];
                got.done_ch     = m_tuser[1 +: CH_W];
                if (want_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    want = want_results.pop_front();
                    check_field("near_left", got.near_left, want.near_left);
                    check_field("near_middle", got.near_middle, want.near_middle);
                    check_field("near_right", got.near_right, want.near_right);
                    check_field("serving_channel", got.serving, want.serving);
                    check_field("average_done", got.avg_done, want.avg_done);
                    check_field("done_channel", got.done_ch, want.done_ch);
                    check_field("done_sum", got.done_sum, want.done_sum);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready) begin
                want_results.push_back(range_step(s_tuser[CH_W-1:0], s_tuser[CH_W],
                                                  s_tdata[TIMER_BITS-1:0]));
            end
        end
        pending <= want_results.size();
        serving <= active_sensor;
    end

endmodule

/* tb/three_channel_echo_ranging_alert_tb.sv */
// Testbench top: drives echo edges and settings into the ranging block, gives the verdict.
`timescale 1ns / 1ps

module three_channel_echo_ranging_alert_tb;
    import tcera_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CH_W-1:0]      CH_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int IDLE_PCT        = 12;    // chance of a gap per beat, in percent
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 40;    // idle time before the verdict
    localparam int STALL_LIMIT     = 5000;  // cycles without any beat moving
    localparam int RANDOM_PHASES   = 6;
    localparam int EDGES_PER_PHASE = 36;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int              errors;
    int              pending;
    logic [CH_W-1:0] serving;     // predicted active sensor, one beat behind at most

    logic quiet     = 1'b0;       // no idling on either side while set
    logic hold_go   = 1'b0;       // asks the receiver for its long hold-off
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_cycles = 0;

    // settings as last written, used to aim widths near the bound
    logic [BOUND_W-1:0] set_bound = BOUND_RST;
    logic [TICKS_W-1:0] set_ticks = TICKS_RST;

    always #6 aclk = ~aclk;

    three_channel_echo_ranging_alert u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    echo_range_checker u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .serving   (serving)
    );

    // Receiver: random stalls, none while quiet, one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("three_channel_echo_ranging_alert: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One input beat; returns at the edge that takes it. Valid stays up for
    // a following beat unless a random gap drops it first.
    task automatic send_edge(logic [CH_W-1:0] ch, logic rising, logic [TIMER_BITS-1:0] t);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(t);
        s_tuser  <= {rising, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sender pause until every expected result beat has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Valid is left high so writes can follow back to back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BOUND: set_bound = value[BOUND_W-1:0];
            REG_TICKS: set_ticks = value;
            default: ;
        endcase
    endtask

    // Writes all three settings; unused upper data bits carry junk.
    task automatic configure(logic [BOUND_W-1:0] bound, logic [TICKS_W-1:0] ticks,
                             logic [SAMP_W-1:0] samples);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_BOUND, {junk[CFG_DATA_W-1:BOUND_W], bound});
        write_reg(REG_TICKS, ticks);
        write_reg(REG_SAMPLES, {junk[CFG_DATA_W-1:SAMP_W], samples});
        cfg_valid <= 1'b0;
    endtask

    // Directed round on the active sensor: n rise/fall pairs, then falling
    // edges until the round closes and the next sensor takes over.
    task automatic serve_round(int n, logic [TIMER_BITS-1:0] t0,
                               logic [TIMER_BITS-1:0] width);
        logic [CH_W-1:0] ch;
        ch = serving;
        repeat (n) begin
            send_edge(ch, 1'b1, t0);
            send_edge(ch, 1'b0, t0 + width);
        end
        wait_drained();
        while (serving == ch) begin
            send_edge(ch, 1'b0, t0 + width);
            wait_drained();
        end
    endtask

    // Well-formed echo: rise then fall on the active sensor, width mostly
    // chosen so the distance lands around the alert bound.
    task automatic send_echo_pair();
        logic [TIMER_BITS-1:0] t0;
        int unsigned           ticks;
        int unsigned           cm;
        int unsigned           w;
        ticks = (set_ticks == '0) ? 1 : set_ticks;
        t0    = TIMER_BITS'($urandom);
        if ($urandom_range(9) == 0) begin
            w = $urandom_range(65535);
        end else begin
            cm = $urandom_range(set_bound + set_bound / 4 + 2);
            w  = cm * ticks + $urandom_range(ticks - 1);
            if (w > 65535) begin
                w = $urandom_range(65535);
            end
        end
        send_edge(serving, 1'b1, t0);
        send_edge(serving, 1'b0, t0 + TIMER_BITS'(w));
    endtask

    initial begin
        logic [CH_W-1:0]    sat_ch;
        logic [BOUND_W-1:0] ph_bound;
        logic [TICKS_W-1:0] ph_ticks;
        logic [SAMP_W-1:0]  ph_samples;
        int                 sent;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: one summed sample on the left sensor (2 cm at 377 ticks/cm)
        // plus edges on idle sensors and the unused channel code.
        send_edge(CH_LEFT, 1'b1, 16'h0000);
        send_edge(CH_LEFT, 1'b0, 16'd754);
        send_edge(CH_UNUSED, 1'b1, 16'hFFFF);
        send_edge(CH_RIGHT, 1'b0, 16'h00FF);
        send_edge(CH_MIDDLE, 1'b1, 16'hAAAA);
        wait_drained();

        // Max bound, zero divisor (acts as 1), one sample per round; a write
        // to the unused index must change nothing.
        write_reg(REG_UNUSED, 16'hFFFF);
        configure(10'd1023, 16'd0, 8'd1);
        serve_round(1, 16'hFFF0, 16'd21);      // left: width wraps through zero
        serve_round(1, 16'h0000, 16'hFFFF);    // middle: widest pulse, far
        serve_round(1, 16'h1234, 16'h0000);    // right: zero width, zero sum
        serve_round(1, 16'h8000, 16'd1023);    // middle on the way back: sum at bound

        // Zero bound, widest divisor, zero samples: first falling edge closes
        // the round with a zero sum.
        configure(10'd0, 16'hFFFF, 8'd0);
        serve_round(0, 16'h0100, 16'h0100);
        serve_round(0, 16'h0200, 16'h0200);

        // Saturation: two samples into a round of three, then the setting drops
        // to one, so the tally wraps and 257 maximal samples pile up. The
        // receiver holds off meanwhile while the sender keeps offering beats.
        configure(10'd1023, 16'd1, 8'd3);
        sat_ch = serving;
        send_edge(sat_ch, 1'b1, 16'h0000);
        send_edge(sat_ch, 1'b0, 16'hFFFF);
        send_edge(sat_ch, 1'b0, 16'hFFFF);
        wait_drained();
        configure(10'd1023, 16'd1, 8'd1);
        hold_go <= 1'b1;
        repeat (255) send_edge(sat_ch, 1'b0, 16'hFFFF);
        wait_drained();
        while (serving == sat_ch) begin
            send_edge(sat_ch, 1'b0, 16'hFFFF);
            wait_drained();
        end

        // Random phases. Sample counts never shrink between phases so a round
        // in progress is not pushed into a long wrap.
        ph_samples = 8'd1;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                ph_bound = 10'd1023;
                ph_ticks = 16'd1;
            end else if (p == RANDOM_PHASES - 1) begin
                ph_bound   = 10'd0;
                ph_ticks   = 16'hFFFF;
                ph_samples = 8'd255;
            end else begin
                ph_bound = BOUND_W'($urandom_range(1023));
                case ($urandom_range(3))
                    0:       ph_ticks = TICKS_RST;
                    1:       ph_ticks = TICKS_W'($urandom_range(1, 64));
                    2:       ph_ticks = TICKS_W'($urandom_range(200, 2000));
                    default: ph_ticks = TICKS_W'($urandom);
                endcase
                ph_samples = ph_samples + SAMP_W'($urandom_range(2));
            end
            configure(ph_bound, ph_ticks, ph_samples);
            quiet <= (p == 2);
            sent = 0;
            while (sent < EDGES_PER_PHASE) begin
                if ($urandom_range(99) < 85) begin
                    send_echo_pair();
                    sent += 2;
                end else begin
                    // noise: any channel code, either edge, any time
                    send_edge(CH_W'($urandom_range(3)), 1'($urandom_range(1)),
                              TIMER_BITS'($urandom));
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("three_channel_echo_ranging_alert: match");
        end else begin
            $display("three_channel_echo_ranging_alert: mismatch");
        end
        $finish;
    end

endmodule

/* three_channel_echo_ranging_alert.f */
+incdir+hdl
hdl/tcera_pkg.sv
hdl/tcera_div.sv
hdl/tcera_dp.sv
hdl/tcera_ctrl.sv
hdl/three_channel_echo_ranging_alert.sv
tb/echo_range_checker.sv
tb/three_channel_echo_ranging_alert_tb.sv
